>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/teq_pkg.sv
// shared types and constants of the timed event queue
package teq_pkg;

    localparam int QUEUE_DEPTH     = 16;
    localparam int SPEED_FRAC_BITS = 8;
    localparam int QIDX_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W          = 48;
    localparam int CMDQ_DEPTH      = 2;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SCHEDULE  = 3'd1,
        OP_REM_FIRST = 3'd2,
        OP_REM_ALL   = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_SPEED  = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]        op;
        logic              tick;
        logic              ran;
        logic [TIME_W-1:0] timeline;
        logic [TIME_W-1:0] sched_time;
        logic [31:0]       scaled;
        logic [7:0]        tag;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  fired_tag;
        logic        ran;
        logic [31:0] elapsed_scaled;
        logic [1:0]  status;
        logic [4:0]  removed_count;
        logic        last;
    } t_res;

endpackage

>>> hw/rtl/timed_event_queue_rate_limiter.sv
// Timed event queue with update rate limit. One item is taken at a time; full stays
// high until the front has handed the classified command on. A tick that runs an
// update passes through the front in order: the remainder of the overshoot by the
// update period, one dividend bit at a time and cut short when the period is zero;
// three 16x16 partial products of the speed scaling; saturation; and hand-off. Every
// other item goes straight to the output register and is handed on from there. The
// back picks a command up, walks or shifts the 16-entry sorted store one entry a cycle
// and then registers the final result; each fired event waits in the output register
// until it is popped, and the walk stalls meanwhile if another event is due. A
// two-deep command queue lets the front take the next item while the back still works
// or waits on pop.
`include "assert_macros.svh"
module timed_event_queue_rate_limiter import teq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_elapsed,
    input  logic [23:0] i_delay,
    input  logic [7:0]  i_tag,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_fired_tag,
    output logic        o_ran,
    output logic [31:0] o_elapsed_scaled,
    output logic [1:0]  o_status,
    output logic [4:0]  o_removed_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0]       r_period;
    logic [15:0]       r_speed;
    logic              w_fv, w_fr, w_bv, w_br, w_rv;
    t_cmd              w_fcmd, w_bcmd;
    t_res              w_res;
    logic [QCNT_W-1:0] w_cnt;
    logic              w_fired_last;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_speed  <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_SPEED:  r_speed  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    teq_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_op, .i_elapsed, .i_delay, .i_tag,
        .i_period(r_period), .i_speed(r_speed),
        .o_cmd_valid(w_fv), .o_cmd(w_fcmd), .i_cmd_ready(w_fr)
    );

    teq_cmd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_wr(w_fv), .o_wr_ready(w_fr), .i_data(w_fcmd),
        .o_rd_valid(w_bv), .i_rd(w_br), .o_data(w_bcmd)
    );

    teq_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_bv), .o_cmd_ready(w_br), .i_cmd(w_bcmd),
        .o_res_valid(w_rv), .o_res(w_res), .i_res_pop(pop), .o_count(w_cnt)
    );

    // result ports
    assign empty            = !w_rv;
    assign o_kind           = w_res.kind;
    assign o_fired_tag      = w_res.fired_tag;
    assign o_ran            = w_res.ran;
    assign o_elapsed_scaled = w_res.elapsed_scaled;
    assign o_status         = w_res.status;
    assign o_removed_count  = w_res.removed_count;
    assign o_last           = w_res.last;

    // a fired event is never the final item of its tick
    assign w_fired_last = w_rv && (w_res.kind == KIND_FIRED) && w_res.last;

    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, w_cnt <= QCNT_W'(QUEUE_DEPTH), "count overflow")
    `ASSERT_CLK(a_fired_not_last, i_clk, i_rst_n, !w_fired_last, "fired item marked last")
    `ASSERT_CLK(a_hold_res, i_clk, i_rst_n, (w_rv && !pop) |=> $stable(w_res), "result not held")
endmodule

>>> hw/rtl/teq_front.sv
// front end: timeline, update rate limit and speed scaling
module teq_front import teq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_elapsed,
    input  logic [23:0] i_delay,
    input  logic [7:0]  i_tag,
    input  logic [31:0] i_period,
    input  logic [15:0] i_speed,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SAT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_timeline, n_timeline;
    logic [TIME_W-1:0] r_last_upd, n_last_upd;
    logic [TIME_W-1:0] r_next_upd, n_next_upd;
    logic [TIME_W-1:0] r_dt, n_dt;
    logic [TIME_W+15:0] r_prod, n_prod;
    logic [1:0]        r_part, n_part;
    logic [15:0]       r_div, n_div;
    logic [16:0]       r_rem, n_rem;
    logic [3:0]        r_bit, n_bit;
    t_cmd              r_cmd, n_cmd;

    logic [TIME_W:0]    w_tl_sum, w_sch_sum, w_nu_sum;
    logic [TIME_W-1:0]  w_tl_sat;
    logic [TIME_W-1:0]  w_diff;
    logic [TIME_W-1:0]  w_tl_less;
    logic [16:0]        w_rem_sh, w_rem_nx;
    logic [31:0]        w_pp16;
    logic [TIME_W+15:0] w_pp;
    logic [TIME_W+15:0] w_shifted;

    assign o_full      = (r_state != S_IDLE);
    assign o_cmd_valid = (r_state == S_OUT);
    assign o_cmd       = r_cmd;

    // saturating adds
    assign w_tl_sum  = {1'b0, r_timeline} + {{(TIME_W-15){1'b0}}, i_elapsed};
    assign w_tl_sat  = w_tl_sum[TIME_W] ? TIME_MAX : w_tl_sum[TIME_W-1:0];
    assign w_sch_sum = {1'b0, r_timeline} + {{(TIME_W-23){1'b0}}, i_delay};

    // overshoot past the next update time, never above one elapsed step
    assign w_diff    = w_tl_sat - r_next_upd;

    // restoring remainder step of the overshoot by the period
    assign w_rem_sh  = {r_rem[15:0], r_div[15]};
    assign w_rem_nx  = ({15'd0, w_rem_sh} >= i_period) ? (w_rem_sh - i_period[16:0])
                                                       : w_rem_sh;

    // next update time: timeline minus remainder plus one period
    assign w_tl_less = r_timeline - {{(TIME_W-17){1'b0}}, r_rem};
    assign w_nu_sum  = {1'b0, w_tl_less} + {{(TIME_W-31){1'b0}}, i_period};

    // 16-bit slices of dt times speed
    assign w_pp16    = {16'd0, r_dt[r_part*16 +: 16]} * {16'd0, i_speed};
    assign w_pp      = {32'd0, w_pp16} << (r_part * 16);
    assign w_shifted = r_prod >> SPEED_FRAC_BITS;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_timeline = r_timeline;
        n_last_upd = r_last_upd;
        n_next_upd = r_next_upd;
        n_dt       = r_dt;
        n_prod     = r_prod;
        n_part     = r_part;
        n_div      = r_div;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_cmd      = r_cmd;
        case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_cmd.op         = i_op;
                    n_cmd.tag        = i_tag;
                    n_cmd.tick       = (i_op == OP_TICK);
                    n_cmd.ran        = 1'b0;
                    n_cmd.scaled     = '0;
                    n_cmd.sched_time = w_sch_sum[TIME_W] ? TIME_MAX
                                                         : w_sch_sum[TIME_W-1:0];
                    n_cmd.timeline   = r_timeline;
                    n_state          = S_OUT;
                    if (i_op == OP_TICK) begin
                        n_timeline     = w_tl_sat;
                        n_cmd.timeline = w_tl_sat;
                        if (w_tl_sat >= r_next_upd) begin
                            n_cmd.ran  = 1'b1;
                            n_dt       = w_tl_sat - r_last_upd;
                            n_last_upd = w_tl_sat;
                            n_prod     = '0;
                            n_part     = '0;
                            n_div      = w_diff[15:0];
                            n_rem      = '0;
                            n_bit      = '0;
                            if (i_period == '0) begin
                                n_next_upd = w_tl_sat;
                            end
                            n_state = S_ADV;
                        end
                    end
                end
            end
            // remainder of the overshoot by the period, one dividend bit a cycle
            S_ADV: begin
                n_div = {r_div[14:0], 1'b0};
                n_rem = w_rem_nx;
                n_bit = r_bit + 4'd1;
                if (i_period == '0 || r_bit == 4'd15) begin
                    n_state = S_MUL;
                end
            end
            // one 16x16 partial product a cycle
            S_MUL: begin
                n_prod = r_prod + w_pp;
                n_part = r_part + 2'd1;
                // next update one period past the last whole period reached
                if (r_part == 2'd0 && i_period != '0) begin
                    n_next_upd = w_nu_sum[TIME_W] ? TIME_MAX : w_nu_sum[TIME_W-1:0];
                end
                if (r_part == 2'd2) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_cmd.scaled = (w_shifted[TIME_W+15:32] != '0) ? 32'hFFFF_FFFF
                                                               : w_shifted[31:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_cmd_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_timeline <= '0;
            r_last_upd <= '0;
            r_next_upd <= '0;
        end else begin
            r_state    <= n_state;
            r_timeline <= n_timeline;
            r_last_upd <= n_last_upd;
            r_next_upd <= n_next_upd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dt   <= n_dt;
        r_prod <= n_prod;
        r_part <= n_part;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_cmd  <= n_cmd;
    end
endmodule

>>> hw/rtl/teq_cmd_fifo.sv
// short command queue between front and back
module teq_cmd_fifo import teq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    output logic o_wr_ready,
    input  t_cmd i_data,
    output logic o_rd_valid,
    input  logic i_rd,
    output t_cmd o_data
);
    t_cmd       r_mem [CMDQ_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'(CMDQ_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign w_wr       = i_wr && o_wr_ready;
    assign w_rd       = i_rd && o_rd_valid;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

>>> hw/rtl/teq_back.sv
// back end: sorted event store, firing, removal and result register
module teq_back import teq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_res_pop,
    output logic [QCNT_W-1:0] o_count
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_EMIT  = 5'b01000,
        S_WAIT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_time [QUEUE_DEPTH];
    logic [7:0]        r_tag  [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] r_idx;
    logic [QCNT_W-1:0] r_rd, r_wr;
    logic [QCNT_W-1:0] r_removed;
    logic              r_res_v;
    t_res              r_res, n_res;
    logic              w_fire_ok;
    logic              w_res_load;
    t_cmd              r_cmd;
    logic [QIDX_W-1:0] w_i;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;
    assign o_count     = r_cnt;
    assign w_i         = r_idx[QIDX_W-1:0];

    // head entry of the walk is due on this tick
    assign w_fire_ok  = r_cmd.tick && (r_rd != r_cnt)
                        && (r_time[r_rd[QIDX_W-1:0]] <= r_cmd.timeline);
    // result register takes a new item
    assign w_res_load = (r_state == S_WALK && w_fire_ok && !r_res_v)
                        || (r_state == S_EMIT && (!r_res_v || i_res_pop));

    // one entry a cycle unless a firing waits on pop: insertion shifts up, removal and firing compact down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= w_res_load || (r_res_v && !i_res_pop);
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd     <= i_cmd;
                        r_removed <= '0;
                        r_rd      <= '0;
                        r_wr      <= '0;
                        r_idx     <= r_cnt;
                        case (i_cmd.op)
                            OP_TICK: r_state <= i_cmd.ran ? S_WALK : S_EMIT;
                            OP_SCHEDULE: r_state <= (r_cnt == QCNT_W'(QUEUE_DEPTH))
                                                    ? S_EMIT : S_SHIFT;
                            OP_REM_FIRST, OP_REM_ALL: r_state <= S_WALK;
                            OP_CLEAR: begin
                                r_removed <= r_cnt;
                                r_cnt     <= '0;
                                r_state   <= S_EMIT;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                // insertion: walk down from the tail
                S_SHIFT: begin
                    if (r_idx != '0 && r_time[w_i - 1'b1] > r_cmd.sched_time) begin
                        r_time[w_i] <= r_time[w_i - 1'b1];
                        r_tag[w_i]  <= r_tag[w_i - 1'b1];
                        r_idx       <= r_idx - 1'b1;
                    end else begin
                        r_time[w_i] <= r_cmd.sched_time;
                        r_tag[w_i]  <= r_cmd.tag;
                        r_cnt       <= r_cnt + 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                // firing or removal: read at r_rd, keep survivors at r_wr
                S_WALK: begin
                    if (w_fire_ok && !r_res_v) begin
                        r_res   <= '{kind: KIND_FIRED, fired_tag: r_tag[r_rd[QIDX_W-1:0]],
                                     ran: 1'b0, elapsed_scaled: '0, status: ST_OK,
                                     removed_count: '0, last: 1'b0};
                        r_rd    <= r_rd + 1'b1;
                    end else if (w_fire_ok) begin
                        r_state <= S_WALK;
                    end else if (r_rd == r_cnt) begin
                        r_cnt   <= r_wr;
                        r_state <= S_EMIT;
                    end else if (!r_cmd.tick && r_tag[r_rd[QIDX_W-1:0]] == r_cmd.tag
                            && (r_cmd.op == OP_REM_ALL || r_removed == '0)) begin
                        r_removed <= r_removed + 1'b1;
                        r_rd      <= r_rd + 1'b1;
                    end else begin
                        r_time[r_wr[QIDX_W-1:0]] <= r_time[r_rd[QIDX_W-1:0]];
                        r_tag[r_wr[QIDX_W-1:0]]  <= r_tag[r_rd[QIDX_W-1:0]];
                        r_wr <= r_wr + 1'b1;
                        r_rd <= r_rd + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_res_v || i_res_pop) begin
                        r_res   <= n_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // final result of the command
    always_comb begin
        n_res = '{kind: KIND_ACK, fired_tag: '0, ran: 1'b0, elapsed_scaled: '0,
                  status: ST_OK, removed_count: '0, last: 1'b1};
        if (r_cmd.tick) begin
            n_res.kind           = KIND_SUMMARY;
            n_res.ran            = r_cmd.ran;
            n_res.elapsed_scaled = r_cmd.scaled;
        end else begin
            case (r_cmd.op)
                OP_SCHEDULE: n_res.status = (r_state == S_EMIT
                                 && r_cnt == QCNT_W'(QUEUE_DEPTH) && r_idx == r_cnt)
                                 ? ST_FULL : ST_OK;
                OP_REM_FIRST, OP_REM_ALL: begin
                    n_res.status        = (r_removed == '0) ? ST_NOT_FOUND : ST_OK;
                    n_res.removed_count = 5'(r_removed);
                end
                OP_CLEAR: n_res.removed_count = 5'(r_removed);
                default: n_res.status = ST_OK;
            endcase
        end
    end
endmodule
